### design/pid_pkg.sv
// Package for the PID angle regulator: widths, codes, microprogram table
// and the clamp helper. No dependencies; all other files depend on it.

package pid_pkg;

  localparam int ANGLE_W = 32;
  localparam int GAIN_W  = 31;
  localparam int OUT_W   = 48;
  localparam int ACT_W   = 2;
  localparam int ACC_W   = 50;
  localparam int MUL_W   = 33;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int ERR_W   = 30;
  localparam int PC_W    = 4;
  localparam int DATA_W  = 64;
  localparam int PADDR_W = 6;
  localparam int IDX_W   = 3;

  localparam logic signed [MUL_W-1:0] PLANT_GAIN_Q24 = 33'sd517174460;

  localparam logic [GAIN_W-1:0]       KP_RESET   = 31'd36438;
  localparam logic [GAIN_W-1:0]       KI_RESET   = 31'd0;
  localparam logic [GAIN_W-1:0]       KD_RESET   = 31'd18350;
  localparam logic signed [OUT_W-1:0] OMIN_RESET = -48'sd13107200000;
  localparam logic signed [OUT_W-1:0] OMAX_RESET = 48'sd13107200000;

  typedef enum logic [ACT_W-1:0] {
    ACT_COMPUTE = 2'd0,
    ACT_AUTO    = 2'd1,
    ACT_MANUAL  = 2'd2
  } action_e;

  typedef enum logic [IDX_W-1:0] {
    REG_KP      = 3'd0,
    REG_KI      = 3'd1,
    REG_KD      = 3'd2,
    REG_OUT_MIN = 3'd3,
    REG_OUT_MAX = 3'd4,
    REG_REVERSE = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_PLANT,
    MUL_KI,
    MUL_KP,
    MUL_KD
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_INT_ADD,
    ACC_SUB_D
  } acc_op_e;

  typedef enum logic {
    CND_NONE,
    CND_SKIP
  } cond_e;

  typedef struct packed {
    mul_sel_e        mul_sel;
    acc_op_e         acc_op;
    logic            err_we;
    logic            int_we;
    logic            out_we;
    logic            misc_we;
    logic            last;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  localparam logic [PC_W-1:0] PC_MISC = 4'd9;

  localparam ucode_t UC_NOP = '{
    mul_sel: MUL_NONE, acc_op: ACC_HOLD, err_we: 1'b0, int_we: 1'b0,
    out_we: 1'b0, misc_we: 1'b0, last: 1'b0, cond: CND_NONE, target: '0
  };

  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = UC_NOP;
    unique case (pc)
      4'd0: begin
        w.mul_sel = MUL_PLANT;
        w.cond    = CND_SKIP;
        w.target  = PC_MISC;
      end
      4'd1: w.err_we = 1'b1;
      4'd2: w.mul_sel = MUL_KI;
      4'd3: w.acc_op = ACC_INT_ADD;
      4'd4: begin
        w.int_we  = 1'b1;
        w.mul_sel = MUL_KP;
      end
      4'd5: w.acc_op = ACC_INT_ADD;
      4'd6: w.mul_sel = MUL_KD;
      4'd7: w.acc_op = ACC_SUB_D;
      4'd8: begin
        w.out_we = 1'b1;
        w.last   = 1'b1;
      end
      4'd9: begin
        w.misc_we = 1'b1;
        w.last    = 1'b1;
      end
      default: w.last = 1'b1;
    endcase
    return w;
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_lim(
    input logic signed [ACC_W-1:0] v,
    input logic signed [OUT_W-1:0] lo,
    input logic signed [OUT_W-1:0] hi
  );
    logic signed [ACC_W-1:0] lo_x;
    logic signed [ACC_W-1:0] hi_x;
    lo_x = ACC_W'(lo);
    hi_x = ACC_W'(hi);
    if (v > hi_x) begin
      return hi;
    end else if (v < lo_x) begin
      return lo;
    end
    return v[OUT_W-1:0];
  endfunction

endpackage

### design/pid_in_if.sv
// Input channel of the PID angle regulator: valid/ready plus one input word.
// Depends on pid_pkg for field widths.

interface pid_in_if;
  logic                                valid;
  logic                                ready;
  logic [pid_pkg::ACT_W-1:0]           action;
  logic signed [pid_pkg::ANGLE_W-1:0]  measured;
  logic signed [pid_pkg::ANGLE_W-1:0]  setpoint;
  logic signed [pid_pkg::OUT_W-1:0]    manual_output;

  modport source (output valid, action, measured, setpoint, manual_output, input ready);
  modport sink   (input valid, action, measured, setpoint, manual_output, output ready);
endinterface

### design/pid_out_if.sv
// Output channel of the PID angle regulator: valid/ready plus one result word.
// Depends on pid_pkg for field widths.

interface pid_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [pid_pkg::OUT_W-1:0] drive_output;
  logic                             updated;

  modport source (output valid, drive_output, updated, input ready);
  modport sink   (input valid, drive_output, updated, output ready);
endinterface

### design/pid_angle_regulator.sv
// PID angle regulator top level: microcoded sequencer over one shared multiplier.
// Depends on pid_pkg, pid_in_if and pid_out_if.
//
// One word in, one word out. A compute word in automatic mode runs nine
// microcode steps through a single 33x33 signed multiplier (error scaling,
// integral term, proportional term, derivative term, in turn), so such a word
// occupies the block from acceptance until its last step hands over the result;
// mode switches and compute words in manual mode branch at the first step to
// the last step. The result sits in an output register, so a new word
// is taken while the previous result waits; the last step stalls only if that
// register is still full. Gains, limits and the reverse flag sit behind an APB
// port at byte address 8*index and must only be written while the block is idle.

module pid_angle_regulator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  pid_in_if.sink                           in_i,
  pid_out_if.source                        out_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pid_pkg::PADDR_W-1:0]      paddr,
  input  logic [pid_pkg::DATA_W-1:0]       pwdata,
  output logic [pid_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);
  import pid_pkg::*;

  logic [GAIN_W-1:0]        kp_q, ki_q, kd_q;
  logic signed [OUT_W-1:0]  omin_q, omax_q;
  logic                     rev_q;
  logic                     cfg_we;
  cfg_idx_e                 cfg_idx;

  logic                     busy_q;
  logic [PC_W-1:0]          pc_q, pc_d;
  ucode_t                   uc;
  logic                     in_acc, advance, out_free, out_push;

  logic [ACT_W-1:0]         action_q;
  logic signed [ANGLE_W-1:0] meas_q, setp_q;
  logic signed [OUT_W-1:0]  manual_q;

  logic signed [OUT_W-1:0]  integral_q, integral_d;
  logic signed [ANGLE_W-1:0] prev_q, prev_d;
  logic                     auto_q, auto_d;
  logic signed [OUT_W-1:0]  held_q, held_d;

  logic signed [MUL_W-1:0]  diff, delta, mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ERR_W-1:0]  err_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d, sh20, sh28;
  logic                     run_ok;

  logic                     out_valid_q;
  logic signed [OUT_W-1:0]  out_drive_q;
  logic                     out_upd_q;

  function automatic logic signed [MUL_W-1:0] sgain(input logic [GAIN_W-1:0] g,
                                                    input logic rev);
    logic signed [MUL_W-1:0] s;
    s = $signed({2'b00, g});
    return rev ? -s : s;
  endfunction

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = cfg_idx_e'(paddr[PADDR_W-1:PADDR_W-IDX_W]);
  assign cfg_we  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q   <= KP_RESET;
      ki_q   <= KI_RESET;
      kd_q   <= KD_RESET;
      omin_q <= OMIN_RESET;
      omax_q <= OMAX_RESET;
      rev_q  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_KP:      kp_q   <= pwdata[GAIN_W-1:0];
        REG_KI:      ki_q   <= pwdata[GAIN_W-1:0];
        REG_KD:      kd_q   <= pwdata[GAIN_W-1:0];
        REG_OUT_MIN: omin_q <= pwdata[OUT_W-1:0];
        REG_OUT_MAX: omax_q <= pwdata[OUT_W-1:0];
        REG_REVERSE: rev_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_KP:      prdata = DATA_W'(kp_q);
      REG_KI:      prdata = DATA_W'(ki_q);
      REG_KD:      prdata = DATA_W'(kd_q);
      REG_OUT_MIN: prdata = DATA_W'(omin_q);
      REG_OUT_MAX: prdata = DATA_W'(omax_q);
      REG_REVERSE: prdata = DATA_W'(rev_q);
      default:     prdata = '0;
    endcase
  end

  // sequencer
  assign in_i.ready = ~busy_q;
  assign in_acc     = in_i.valid & ~busy_q;
  assign uc         = ucode(pc_q);
  assign out_free   = ~out_valid_q | out_o.ready;
  assign advance    = busy_q & (~uc.last | out_free);
  assign out_push   = busy_q & uc.last & out_free;
  assign run_ok     = (action_e'(action_q) == ACT_COMPUTE) & auto_q;

  always_comb begin
    pc_d = pc_q + 1'b1;
    if (uc.cond == CND_SKIP && !run_ok) begin
      pc_d = uc.target;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
    end else if (in_acc) begin
      busy_q <= 1'b1;
      pc_q   <= '0;
    end else if (out_push) begin
      busy_q <= 1'b0;
    end else if (advance) begin
      pc_q <= pc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      action_q <= in_i.action;
      meas_q   <= in_i.measured;
      setp_q   <= in_i.setpoint;
      manual_q <= in_i.manual_output;
    end
  end

  // datapath
  assign diff  = MUL_W'(setp_q) - MUL_W'(meas_q);
  assign delta = MUL_W'(meas_q) - MUL_W'(prev_q);
  assign sh20  = ACC_W'($signed(prod_q[PROD_W-1:20]));
  assign sh28  = ACC_W'($signed(prod_q[PROD_W-1:28]));

  always_comb begin
    unique case (uc.mul_sel)
      MUL_PLANT: begin
        mul_a = diff;
        mul_b = PLANT_GAIN_Q24;
      end
      MUL_KI: begin
        mul_a = sgain(ki_q, rev_q);
        mul_b = MUL_W'(err_q);
      end
      MUL_KP: begin
        mul_a = sgain(kp_q, rev_q);
        mul_b = MUL_W'(err_q);
      end
      MUL_KD: begin
        mul_a = sgain(kd_q, rev_q);
        mul_b = delta;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    unique case (uc.acc_op)
      ACC_INT_ADD: acc_d = ACC_W'(integral_q) + sh20;
      ACC_SUB_D:   acc_d = acc_q - sh28;
      default:     acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (uc.mul_sel != MUL_NONE) begin
        prod_q <= mul_a * mul_b;
      end
      if (uc.err_we) begin
        err_q <= prod_q[ERR_W+31:32];
      end
      acc_q <= acc_d;
    end
  end

  always_comb begin
    integral_d = integral_q;
    prev_d     = prev_q;
    auto_d     = auto_q;
    held_d     = held_q;
    if (uc.int_we) begin
      integral_d = clamp_lim(acc_q, omin_q, omax_q);
    end
    if (uc.out_we) begin
      held_d = clamp_lim(acc_q, omin_q, omax_q);
      prev_d = meas_q;
    end
    if (uc.misc_we) begin
      case (action_e'(action_q))
        ACT_AUTO: begin
          if (!auto_q) begin
            integral_d = clamp_lim(ACC_W'(manual_q), omin_q, omax_q);
            prev_d     = meas_q;
            held_d     = manual_q;
            auto_d     = 1'b1;
          end
        end
        ACT_MANUAL: auto_d = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integral_q <= '0;
      prev_q     <= '0;
      auto_q     <= 1'b0;
      held_q     <= '0;
    end else if (advance) begin
      integral_q <= integral_d;
      prev_q     <= prev_d;
      auto_q     <= auto_d;
      held_q     <= held_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_push) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      out_drive_q <= held_d;
      out_upd_q   <= uc.out_we;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.drive_output = out_drive_q;
  assign out_o.updated      = out_upd_q;

  a_push_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> busy_q)
    else $error("result pushed while sequencer idle");

  a_start_pc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> busy_q && pc_q == '0)
    else $error("sequencer did not start at step zero");

  a_upd_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_push && uc.out_we) |-> run_ok)
    else $error("update flagged for a word that is not an automatic compute");

  a_int_lim : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && uc.int_we) |=>
      (!$stable(omin_q) || !$stable(omax_q) || omin_q > omax_q ||
       (integral_q <= omax_q && integral_q >= omin_q)))
    else $error("integral left the clamp range");

endmodule
